// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define AST_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define AST_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ssfbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfbm_pkg
// Shared constants, codes and types of the sequence store.
// ----------------------------------------------------------------------------
package ssfbm_pkg;

  localparam int DEPTH     = 32;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  // operation codes
  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_INS_MID    = 4'd2;
  localparam logic [3:0] OP_POP_FRONT  = 4'd3;
  localparam logic [3:0] OP_POP_BACK   = 4'd4;
  localparam logic [3:0] OP_DEL_MID    = 4'd5;
  localparam logic [3:0] OP_COUNT      = 4'd6;
  localparam logic [3:0] OP_FWD        = 4'd7;
  localparam logic [3:0] OP_BWD        = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // cell commands
  localparam logic [2:0] K_HOLD = 3'd0;
  localparam logic [2:0] K_INS  = 3'd1;
  localparam logic [2:0] K_DEL  = 3'd2;
  localparam logic [2:0] K_ROTL = 3'd3;
  localparam logic [2:0] K_ROTR = 3'd4;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] last_idx;
    word_t            value;
  } cell_cmd_t;

endpackage

// ===== rtl/ssfbm_cell.sv =====
// ----------------------------------------------------------------------------
// ssfbm_cell
// One storage cell of the chain; takes its own, a neighbor's, the wrap or a new word.
// ----------------------------------------------------------------------------
module ssfbm_cell
  import ssfbm_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] idx,
  input  word_t            left_word,
  input  word_t            right_word,
  input  word_t            wrap_word,
  output word_t            word_q
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (cmd.kind)
      K_INS: begin
        if (idx > cmd.pos) begin
          word_nxt = left_word;
        end else if (idx == cmd.pos) begin
          word_nxt = cmd.value;
        end
      end
      K_DEL: begin
        if (idx >= cmd.pos) begin
          word_nxt = right_word;
        end
      end
      K_ROTL: begin
        if (idx == cmd.last_idx) begin
          word_nxt = wrap_word;
        end else if (idx < cmd.last_idx) begin
          word_nxt = right_word;
        end
      end
      K_ROTR: begin
        if (idx == '0) begin
          word_nxt = wrap_word;
        end else if (idx <= cmd.last_idx) begin
          word_nxt = left_word;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// ===== rtl/sequence_store_front_back_middle.sv =====
// ----------------------------------------------------------------------------
// sequence_store_front_back_middle
// Bounded deque of signed words with middle insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, in_op, in_value) carries one operation
//   per transaction. Result channel (out_valid/out_stall, out_element,
//   out_count, out_status, out_last) returns one result per update, count or
//   empty traversal, and one result per held word for a traversal.
//   Words sit in a row of cells; an update shifts cells from its position on.
//   A non-traversal result is in the output register the cycle after its
//   input transaction; a traversal first enters the ST_TRAV state, which
//   loads its first word once the output register is free.
//   Throughput: one update per cycle while the receiver keeps up; an input is
//   taken only when the output register is empty or drains in that cycle.
//   A traversal of n words emits one word per cycle while the receiver keeps
//   up, rotating the chain (head or tail cell is read), and holds the input
//   off until its last word is loaded; the output rate sets the throughput.
//   Reset clears the count, the traversal state and the output valid; cell
//   contents are left as they are and are never read before being written.
//   When the receiver stalls, the output register holds its result and the
//   block stops accepting inputs or advancing a traversal.
// ----------------------------------------------------------------------------
module sequence_store_front_back_middle
  import ssfbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_element,
  output logic [5:0]         out_count,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  // control state
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] length_r, length_nxt;
  logic [IDX_W-1:0] trav_r, trav_nxt;
  logic             bwd_r, bwd_nxt;
  logic             out_valid_r, out_valid_nxt;

  // output payload
  logic signed [31:0] out_element_r;
  logic [5:0]         out_count_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  logic               load_out;
  logic signed [31:0] ld_elem;
  logic [1:0]         ld_status;
  logic               ld_last;

  logic             accept, out_free, full, empty, trav_end;
  logic [2:0]       cmd_kind;
  logic [IDX_W-1:0] cmd_pos, last_idx;
  cell_cmd_t        cmd;
  word_t            word_w [DEPTH];
  word_t            tail_word, wrap_word;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_TRAV) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (length_r == CNT_W'(DEPTH));
  assign empty    = (length_r == '0);

  // last occupied cell, meaningful only when not empty
  assign last_idx  = IDX_W'(length_r - CNT_W'(1));
  assign cmd       = '{kind: cmd_kind, pos: cmd_pos, last_idx: last_idx,
                       value: WORD_BITS'(in_value)};
  assign tail_word = word_w[last_idx];
  assign wrap_word = bwd_r ? tail_word : word_w[0];
  assign trav_end  = (trav_r == last_idx);

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lw, rw;
    if (i == 0) begin : g_first
      assign lw = '0;
    end else begin : g_left
      assign lw = word_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rw = '0;
    end else begin : g_right
      assign rw = word_w[i+1];
    end
    ssfbm_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(i)),
      .left_word  (lw),
      .right_word (rw),
      .wrap_word  (wrap_word),
      .word_q     (word_w[i])
    );
  end

  // ---- control ----
  always_comb begin
    state_nxt     = state_r;
    length_nxt    = length_r;
    trav_nxt      = trav_r;
    bwd_nxt       = bwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    load_out      = 1'b0;
    ld_elem       = '0;
    ld_status     = ST_OK;
    ld_last       = 1'b1;
    cmd_kind      = K_HOLD;
    cmd_pos       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INS_MID: begin
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                cmd_kind   = K_INS;
                length_nxt = length_r + CNT_W'(1);
                if (in_op == OP_PUSH_BACK) begin
                  cmd_pos = IDX_W'(length_r);
                end else if (in_op == OP_INS_MID) begin
                  cmd_pos = IDX_W'(length_r >> 1);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DEL_MID: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                cmd_kind   = K_DEL;
                length_nxt = length_r - CNT_W'(1);
                if (in_op == OP_POP_BACK) begin
                  cmd_pos = last_idx;
                end else if (in_op == OP_DEL_MID) begin
                  cmd_pos = IDX_W'(length_r >> 1);
                end
              end
            end
            OP_FWD, OP_BWD: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                // traversal results come from the ST_TRAV state
                load_out  = 1'b0;
                state_nxt = ST_TRAV;
                trav_nxt  = '0;
                bwd_nxt   = (in_op == OP_BWD);
              end
            end
            default: ld_status = ST_OK;  // count and unused codes
          endcase
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_last  = trav_end;
          ld_elem  = bwd_r ? 32'(tail_word) : 32'(word_w[0]);
          cmd_kind = bwd_r ? K_ROTR : K_ROTL;
          if (trav_end) begin
            state_nxt = ST_IDLE;
            trav_nxt  = '0;
          end else begin
            trav_nxt = trav_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      length_r    <= '0;
      trav_r      <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      trav_r      <= trav_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, count is the value after the operation
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_element_r <= ld_elem;
      out_count_r   <= 6'(length_nxt);
      out_status_r  <= ld_status;
      out_last_r    <= ld_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/ssfbm_checker.sv =====
// ----------------------------------------------------------------------------
// ssfbm_props
// Port-level checks of the sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssfbm_props
  import ssfbm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_element,
  input logic [5:0]         out_count,
  input logic [1:0]         out_status,
  input logic               out_last
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_count)
                               && $stable(out_status) && $stable(out_last);
  endproperty

  property p_status_code;
    out_valid |-> (out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_FULL);
  endproperty

  property p_empty_shape;
    out_valid && out_status == ST_EMPTY |-> out_last && out_count == '0 && out_element == '0;
  endproperty

  // stalled result holds
  `AST_RST(a_out_hold, clk, rst_n, p_out_hold, "stalled result changed")

  // only the three defined status codes appear
  `AST_RST(a_status_code, clk, rst_n, p_status_code, "bad status code")

  // an empty report is a single final result with nothing held
  `AST_RST(a_empty_shape, clk, rst_n, p_empty_shape, "malformed empty result")

  // no new transaction while a traversal is still emitting
  `AST_RST(a_trav_blocks, clk, rst_n, out_valid && !out_last |-> in_stall, "input taken mid traversal")

endmodule

bind sequence_store_front_back_middle ssfbm_props u_ssfbm_props (.*);

// ===== dv/ssfbm_checker.sv =====
// ----------------------------------------------------------------------------
// ssfbm_checker
// Watches both channels of the sequence store, keeps its own copy of the
// held words, predicts the results of every input transaction and compares
// them in order with the results the block returns.
// ----------------------------------------------------------------------------
module ssfbm_checker
  import ssfbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_element,
  input  logic [5:0]         out_count,
  input  logic [1:0]         out_status,
  input  logic               out_last,
  output int                 mismatches,
  output int                 pending,
  output int                 ops_seen,
  output int                 results_seen,
  output int                 full_rejects,
  output int                 empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [31:0] element;
    logic [5:0]         count;
    logic [1:0]         status;
    logic               last;
  } result_t;

  word_t   cells [DEPTH];
  int      held = 0;
  result_t awaited_results [$];

  function automatic logic [1:0] insert_word(input int pos, input word_t w);
    if (held >= DEPTH) return ST_FULL;
    for (int i = held; i > pos; i--) cells[i] = cells[i-1];
    cells[pos] = w;
    held++;
    return ST_OK;
  endfunction

  function automatic logic [1:0] remove_word(input int pos);
    if (held == 0) return ST_EMPTY;
    if (pos >= held) pos = held - 1;
    for (int i = pos; i < held - 1; i++) cells[i] = cells[i+1];
    held--;
    return ST_OK;
  endfunction

  // updates the held words and queues every result the operation causes
  task automatic apply_deque_op(input logic [3:0] op, input logic signed [31:0] value);
    word_t      w;
    logic [1:0] st;
    result_t    r;
    int         idx;
    w  = word_t'(value);
    st = ST_OK;
    case (op)
      OP_PUSH_FRONT: st = insert_word(0, w);
      OP_PUSH_BACK:  st = insert_word(held, w);
      OP_INS_MID:    st = insert_word(held / 2, w);
      OP_POP_FRONT:  st = remove_word(0);
      OP_POP_BACK:   st = remove_word((held == 0) ? 0 : held - 1);
      OP_DEL_MID:    st = remove_word(held / 2);
      OP_FWD, OP_BWD: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < held; i++) begin
            idx       = (op == OP_FWD) ? i : held - 1 - i;
            r.element = cells[idx];
            r.count   = 6'(held);
            r.status  = ST_OK;
            r.last    = (i == held - 1);
            awaited_results.push_back(r);
          end
          return;
        end
      end
      default: st = ST_OK;
    endcase
    if (st == ST_FULL) full_rejects++;
    if (st == ST_EMPTY) empty_hits++;
    r = '{32'sd0, 6'(held), st, 1'b1};
    awaited_results.push_back(r);
  endtask

  task automatic report_failure(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t %s: expected elem=%0d cnt=%0d st=%0d last=%0d",
               $realtime, why, want.element, want.count, want.status, want.last);
      $display("    got elem=%0d cnt=%0d st=%0d last=%0d",
               got.element, got.count, got.status, got.last);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      // results first: a result leaving now never belongs to an input taken now
      if (out_valid && !out_stall) begin
        results_seen++;
        got = '{out_element, out_count, out_status, out_last};
        if (awaited_results.size() == 0) begin
          report_failure("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) report_failure("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        ops_seen++;
        apply_deque_op(in_op, in_value);
      end
      pending <= awaited_results.size();
    end
  end

endmodule

// ===== dv/sequence_store_front_back_middle_tb.sv =====
// ----------------------------------------------------------------------------
// sequence_store_front_back_middle_tb
// Drives operations into the sequence store with bursty traffic and a
// stalling receiver; a checker beside the block predicts and compares every
// result. Directed corner cases first, then a random fill past capacity,
// then random segments that grow, shrink or mix the list and traverse it.
// ----------------------------------------------------------------------------
module sequence_store_front_back_middle_tb;
  import ssfbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RANDOM_ITEMS = 280;
  localparam int         IDLE_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int         DRAIN_CYCLES = 8;     // settle time after the last result
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;  // codes the block treats as no-op
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

  // every block input has a known value from time zero
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [3:0]         in_op     = OP_COUNT;
  logic signed [31:0] in_value  = '0;
  logic               out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] out_element;
  logic [5:0]         out_count;
  logic [1:0]         out_status;
  logic               out_last;

  int mismatches, pending, ops_seen, results_seen, full_rejects, empty_hits;

  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          idle_cycles = 0;

  always #2 clk = ~clk;

  sequence_store_front_back_middle uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_element(out_element),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (out_last)
  );

  ssfbm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_element (out_element),
    .out_count   (out_count),
    .out_status  (out_status),
    .out_last    (out_last),
    .mismatches  (mismatches),
    .pending     (pending),
    .ops_seen    (ops_seen),
    .results_seen(results_seen),
    .full_rejects(full_rejects),
    .empty_hits  (empty_hits)
  );

  // Receiver: picks a stall mode, keeps it for a while, then picks again.
  // STALL_NONE gives stretches where results drain at full rate.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("[sequence_store_front_back_middle] ERROR");
        $finish;
      end
    end
  end

  // Mostly ordinary words, often the extremes and the all-zero / all-one words.
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_push();
    case ($urandom_range(0, 2))
      0:       return OP_PUSH_FRONT;
      1:       return OP_PUSH_BACK;
      default: return OP_INS_MID;
    endcase
  endfunction

  function automatic logic [3:0] pick_pop();
    case ($urandom_range(0, 2))
      0:       return OP_POP_FRONT;
      1:       return OP_POP_BACK;
      default: return OP_DEL_MID;
    endcase
  endfunction

  // Weighted operation choice; the mix steers the list toward full or empty.
  function automatic logic [3:0] pick_op(input traffic_mix_t mix);
    int r;
    int push_cut;
    int pop_cut;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:   begin push_cut = 65; pop_cut = 80; end
      MIX_SHRINK: begin push_cut = 20; pop_cut = 80; end
      default:    begin push_cut = 40; pop_cut = 76; end
    endcase
    if (r < push_cut) return pick_push();
    if (r < pop_cut) return pick_pop();
    if (r < 91) return ($urandom_range(0, 1) == 0) ? OP_FWD : OP_BWD;
    if (r < 97) return OP_COUNT;
    return 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
  endfunction

  // One input transaction. Called at a rising edge; returns at the edge the
  // block takes it. A burst ends in a random gap with valid low.
  task automatic send_op(input logic [3:0] op, input logic signed [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int           sent;
    int           seg_left;
    traffic_mix_t mix;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: empty list, one and two words, extremes, unused codes ---
    send_op(OP_POP_FRONT, $urandom);               // removals on empty report empty
    send_op(OP_POP_BACK,  $urandom);
    send_op(OP_DEL_MID,   $urandom);
    send_op(OP_FWD,       $urandom);               // empty traversal: single result
    send_op(OP_BWD,       $urandom);
    send_op(OP_COUNT,     $urandom);               // count on empty is still ok
    send_op(OP_INS_MID,   32'sh7fffffff);          // middle insert into empty
    send_op(OP_INS_MID,   32'sh80000000);          // into one word: lands at front
    send_op(OP_FWD,       $urandom);
    send_op(OP_DEL_MID,   $urandom);               // from two words: back one goes
    send_op(OP_PUSH_BACK, -32'sd1);
    send_op(OP_PUSH_FRONT, 32'sh0);
    send_op(OP_PUSH_BACK, 32'sh55555555);
    send_op(OP_INS_MID,   32'shAAAAAAAA);
    send_op(OP_COUNT,     $urandom);
    send_op(OP_BWD,       $urandom);
    send_op(OP_FWD,       $urandom);
    send_op(OP_UNUSED_LO, $urandom);
    send_op(OP_UNUSED_HI, $urandom);
    send_op(OP_DEL_MID,   $urandom);
    send_op(OP_POP_FRONT, $urandom);
    send_op(OP_POP_BACK,  $urandom);
    send_op(OP_POP_BACK,  $urandom);
    send_op(OP_POP_BACK,  $urandom);
    send_op(OP_COUNT,     $urandom);
    drain_results();

    // --- random: first fill past capacity so the full-store reject shows up ---
    sent = 0;
    repeat (DEPTH + 3) begin
      send_op(pick_push(), rand_word());
      sent++;
    end
    send_op(OP_BWD, $urandom);                     // longest traversal
    sent++;
    drain_results();

    // then segments that each lean toward growing, shrinking or neither
    seg_left = 0;
    mix      = MIX_BALANCED;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        mix      = traffic_mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 40);
      end
      send_op(pick_op(mix), rand_word());
      sent++;
      seg_left--;
      if (sent == RANDOM_ITEMS / 2) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations, %0d results checked, %0d full-store rejects,",
             ops_seen, results_seen, full_rejects);
    $display("%0d empty cases; bursty sender, four receiver stall modes, %0d mismatches",
             empty_hits, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[sequence_store_front_back_middle] OK");
    end else begin
      $display("[sequence_store_front_back_middle] ERROR");
    end
    $finish;
  end

endmodule
